@@ hw/rtl/tdn_pkg.sv @@
// Shared types, constants and helper functions for the triangle dof numbering block.
// No dependencies; every other file in hw/rtl imports this package.
package tdn_pkg;

	localparam int EDGE_TABLE_DEPTH = 4096;
	localparam int MAX_ORDER        = 8;
	localparam int VERTEX_BITS      = 16;

	localparam int ID_W      = 24;
	localparam int ORDER_W   = 4;
	localparam int POINT_W   = 16;
	localparam int FIELD_W   = 16;
	localparam int TRI_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam int KEY_W       = 2 * VERTEX_BITS;
	localparam int EDGE_ADDR_W = $clog2(EDGE_TABLE_DEPTH);
	localparam int EDGE_CNT_W  = $clog2(EDGE_TABLE_DEPTH + 1);
	localparam int PM1_W       = $clog2(MAX_ORDER + 1);
	localparam int INNER_MAX   = ((MAX_ORDER - 1) * (MAX_ORDER - 2)) / 2;
	localparam int INNER_W     = $clog2(INNER_MAX + 2);
	localparam int CNT_W       = $clog2(INNER_MAX + 4);

	// item action codes
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORDER  = 1'b0,
		CFG_POINTS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               action;
		logic [FIELD_W-1:0] vertex_a;
		logic [FIELD_W-1:0] vertex_b;
		logic [FIELD_W-1:0] vertex_c;
		logic [FIELD_W-1:0] element_index;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] dof_id;
		logic            last;
		logic            table_overflow;
		logic [ID_W-1:0] total_dofs;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_TOTAL,
		ST_EMIT_VTX,
		ST_EMIT_EDGE,
		ST_EMIT_INT
	} state_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_VTX,
		EM_EDGE,
		EM_INT
	} emit_t;

	typedef struct packed {
		logic  load;
		logic  search;
		logic  total;
		emit_t emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic new_query;
		logic is_query;
		logic order_gt1;
		logic inner_zero;
		logic edge_done;
		logic edge_last;
		logic cnt_end;
	} ctl_stat_t;

	// p-1 with p clamped to 1..MAX_ORDER
	function automatic logic [PM1_W-1:0] order_minus1(input logic [ORDER_W-1:0] order);
		logic [PM1_W-1:0] r;
		if (order == '0)
			r = '0;
		else if (order > ORDER_W'(MAX_ORDER))
			r = PM1_W'(MAX_ORDER - 1);
		else
			r = PM1_W'(order - 1'b1);
		return r;
	endfunction

	// (p-1)(p-2)/2 interior nodes
	function automatic logic [INNER_W-1:0] inner_count(input logic [PM1_W-1:0] pm1);
		logic [2*PM1_W-1:0] prod;
		logic [INNER_W-1:0] r;
		prod = {{PM1_W{1'b0}}, pm1} * {{PM1_W{1'b0}}, PM1_W'(pm1 - 1'b1)};
		if (pm1 < PM1_W'(2))
			r = '0;
		else
			r = INNER_W'(prod >> 1);
		return r;
	endfunction

endpackage

@@ hw/rtl/tdn_datapath.sv @@
// Datapath: config registers, counters, edge table memory with linear search, id emission.
// Depends on tdn_pkg; driven by tdn_ctrl through ctl_cmd_t / ctl_stat_t.
module tdn_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdn_pkg::item_t              item,
	input  logic                        cfg_we,
	input  logic [tdn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tdn_pkg::CFG_W-1:0]   cfg_data,
	input  tdn_pkg::ctl_cmd_t           cmd,
	output tdn_pkg::ctl_stat_t          stat,
	output logic                        valid,
	output tdn_pkg::result_t            result
);
	import tdn_pkg::*;

	// control state
	logic [ORDER_W-1:0]    order_q;
	logic [ID_W-1:0]       next_id_q;
	logic [EDGE_CNT_W-1:0] stored_q;
	logic [TRI_W-1:0]      tri_q;
	logic [EDGE_CNT_W-1:0] ptr_q;
	logic                  pend_q;
	logic [1:0]            e_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  dropped_q;
	logic                  act_q;
	logic                  valid_q;

	// payload
	logic [VERTEX_BITS-1:0] va_q, vb_q, vc_q;
	logic [FIELD_W-1:0]     elem_q;
	logic [ID_W-1:0]        start_q [3];
	logic [ID_W-1:0]        total_q;
	logic [ID_W-1:0]        base_q;
	result_t                result_q;

	// edge table: key in the upper bits, first edge id in the lower bits
	logic [KEY_W+ID_W-1:0] mem_q [EDGE_TABLE_DEPTH];
	logic [KEY_W+ID_W-1:0] rd_s1;

	logic [PM1_W-1:0]       pm1;
	logic [INNER_W-1:0]     inner;
	logic [VERTEX_BITS-1:0] ex, ey, lo, hi;
	logic [KEY_W-1:0]       key;
	logic                   hit, scan_end, miss, edge_done, table_full, rd_en, wr_en;
	logic [TRI_W+INNER_W-1:0]   tri_prod;
	logic [FIELD_W+INNER_W-1:0] elem_prod;
	logic                   cnt_end, last;
	logic [ID_W-1:0]        dof;

	assign pm1   = order_minus1(order_q);
	assign inner = inner_count(pm1);

	// edges (a,b), (b,c), (a,c)
	always_comb begin
		ex = (e_q == 2'd1) ? vb_q : va_q;
		ey = (e_q == 2'd0) ? vb_q : vc_q;
		lo = (ex < ey) ? ex : ey;
		hi = (ex < ey) ? ey : ex;
		key = {lo, hi};
	end

	// read issued one cycle, compared the next
	assign table_full = (stored_q == EDGE_CNT_W'(EDGE_TABLE_DEPTH));
	assign hit        = pend_q && (rd_s1[KEY_W+ID_W-1:ID_W] == key);
	assign scan_end   = (ptr_q == stored_q);
	assign miss       = !hit && scan_end;
	assign edge_done  = cmd.search && (hit || miss);
	assign rd_en      = cmd.search && !hit && !scan_end;
	assign wr_en      = cmd.search && miss && !table_full;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[stored_q[EDGE_ADDR_W-1:0]] <= {key, next_id_q};
		if (rd_en)
			rd_s1 <= mem_q[ptr_q[EDGE_ADDR_W-1:0]];
	end

	assign tri_prod  = {{INNER_W{1'b0}}, tri_q} * {{TRI_W{1'b0}}, inner};
	assign elem_prod = {{INNER_W{1'b0}}, elem_q} * {{FIELD_W{1'b0}}, inner};

	always_comb begin
		cnt_end = 1'b0;
		last    = 1'b0;
		dof     = '0;
		case (cmd.emit)
			EM_VTX: begin
				cnt_end = (cnt_q == CNT_W'(2));
				last    = cnt_end && (pm1 == '0);
				if (cnt_q == '0)
					dof = ID_W'(va_q);
				else if (cnt_q == CNT_W'(1))
					dof = ID_W'(vb_q);
				else
					dof = ID_W'(vc_q);
			end
			EM_EDGE: begin
				cnt_end = ((cnt_q + 1'b1) == CNT_W'(pm1));
				last    = cnt_end && (e_q == 2'd2);
				dof     = start_q[e_q] + ID_W'(cnt_q);
			end
			EM_INT: begin
				cnt_end = ((cnt_q + 1'b1) == CNT_W'(inner));
				last    = cnt_end;
				dof     = base_q + ID_W'(cnt_q);
			end
			default: begin
				cnt_end = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q   <= ORDER_W'(1);
			next_id_q <= '0;
			stored_q  <= '0;
			tri_q     <= '0;
			ptr_q     <= '0;
			pend_q    <= 1'b0;
			e_q       <= '0;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			act_q     <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= (cmd.emit != EM_NONE);
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORDER:  order_q   <= cfg_data[ORDER_W-1:0];
					CFG_POINTS: next_id_q <= ID_W'(cfg_data[POINT_W-1:0]);
					default:    order_q   <= order_q;
				endcase
			end
			if (cmd.load) begin
				act_q     <= item.action;
				dropped_q <= 1'b0;
				ptr_q     <= '0;
				pend_q    <= 1'b0;
				e_q       <= '0;
				if (item.action == ACT_ADD)
					tri_q <= tri_q + 1'b1;
			end
			if (cmd.search) begin
				if (edge_done) begin
					ptr_q  <= '0;
					pend_q <= 1'b0;
					e_q    <= e_q + 1'b1;
				end else if (rd_en) begin
					ptr_q  <= ptr_q + 1'b1;
					pend_q <= 1'b1;
				end
				if (miss) begin
					next_id_q <= next_id_q + ID_W'(pm1);
					if (table_full)
						dropped_q <= 1'b1;
					else
						stored_q <= stored_q + 1'b1;
				end
			end
			if (cmd.total) begin
				e_q   <= '0;
				cnt_q <= '0;
			end
			if (cmd.emit != EM_NONE) begin
				if (cnt_end) begin
					cnt_q <= '0;
					if (cmd.emit == EM_EDGE)
						e_q <= e_q + 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			va_q   <= VERTEX_BITS'(item.vertex_a);
			vb_q   <= VERTEX_BITS'(item.vertex_b);
			vc_q   <= VERTEX_BITS'(item.vertex_c);
			elem_q <= item.element_index;
		end
		if (edge_done)
			start_q[e_q] <= hit ? rd_s1[ID_W-1:0] : next_id_q;
		if (cmd.total) begin
			total_q <= next_id_q + ID_W'(tri_prod);
			base_q  <= next_id_q + ID_W'(elem_prod);
		end
		if (cmd.emit != EM_NONE) begin
			result_q.dof_id         <= dof;
			result_q.last           <= last;
			result_q.table_overflow <= dropped_q;
			result_q.total_dofs     <= total_q;
		end
	end

	always_comb begin
		stat.new_query  = (item.action == ACT_QUERY);
		stat.is_query   = (act_q == ACT_QUERY);
		stat.order_gt1  = (pm1 != '0);
		stat.inner_zero = (inner == '0);
		stat.edge_done  = edge_done;
		stat.edge_last  = (e_q == 2'd2);
		stat.cnt_end    = cnt_end;
	end

	assign valid  = valid_q;
	assign result = result_q;

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= EDGE_CNT_W'(EDGE_TABLE_DEPTH))
		else $error("edge table count past depth");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> table_full)
		else $error("overflow flagged with room in edge table");
	a_pend_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (ptr_q != '0))
		else $error("pending compare without an issued read");

endmodule

@@ hw/rtl/tdn_ctrl.sv @@
// Controller state machine: sequences load, edge searches, total, and id emission.
// Depends on tdn_pkg; commands tdn_datapath.
module tdn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tdn_pkg::ctl_stat_t stat,
	output tdn_pkg::ctl_cmd_t  cmd,
	output logic               busy
);
	import tdn_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.search = 1'b0;
		cmd.total  = 1'b0;
		cmd.emit   = EM_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (!stat.new_query && stat.order_gt1) ? ST_SEARCH : ST_TOTAL;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.edge_done && stat.edge_last)
					state_d = ST_TOTAL;
			end
			ST_TOTAL: begin
				cmd.total = 1'b1;
				if (!stat.is_query)
					state_d = ST_EMIT_VTX;
				else if (stat.inner_zero)
					state_d = ST_IDLE;
				else
					state_d = ST_EMIT_INT;
			end
			ST_EMIT_VTX: begin
				cmd.emit = EM_VTX;
				if (stat.cnt_end)
					state_d = stat.order_gt1 ? ST_EMIT_EDGE : ST_IDLE;
			end
			ST_EMIT_EDGE: begin
				cmd.emit = EM_EDGE;
				if (stat.cnt_end && stat.edge_last)
					state_d = ST_IDLE;
			end
			ST_EMIT_INT: begin
				cmd.emit = EM_INT;
				if (stat.cnt_end)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	a_search_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !stat.is_query)
		else $error("edge search during a query");
	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_EDGE) |-> stat.order_gt1)
		else $error("edge ids emitted at order one");
	a_int_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_INT) |-> !stat.inner_zero)
		else $error("interior ids emitted with no interior nodes");

endmodule

@@ hw/rtl/triangle_dof_numbering.sv @@
// Triangle dof numbering top level: controller plus datapath with the edge table memory.
// Depends on tdn_pkg, tdn_ctrl, tdn_datapath.
//
// An item is taken when start is high and busy is low. Results come out one per cycle on
// result with valid high for that single cycle; the receiver cannot stall them. An add item
// is loaded, then for order p > 1 searches the edge table memory for each of its edges,
// each search scanning stored entries one per cycle until a hit or the end of the stored
// entries, then takes a total step, then outputs 3 + 3(p-1) ids. A query is loaded, takes
// the total step and then outputs (p-1)(p-2)/2 interior ids. The linear search over the
// single-port table sets the add time as the table fills. The table needs no clearing after
// reset. Config writes must be made only while busy is low.
module triangle_dof_numbering (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tdn_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [tdn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tdn_pkg::CFG_W-1:0]     cfg_data,
	output logic                          valid,
	output tdn_pkg::result_t              result
);
	import tdn_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	tdn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tdn_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.valid     (valid),
		.result    (result)
	);

endmodule
